### design/ckmd_pkg.sv
// Shared types, constants and helpers for the chroma key matte / despill pipeline.
// No dependencies.
`default_nettype none
package ckmd_pkg;

    localparam int FB = 15;
    localparam logic [15:0] ONE = 16'd32768;
    localparam logic [16:0] THREE_ONE = 17'd98304;
    localparam logic [15:0] ALPHA_THRESH = 16'((32768 + 99) / 100);
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

    localparam logic [1:0] KEY_BLUE   = 2'd1;
    localparam logic [1:0] KEY_CUSTOM = 2'd2;

    localparam logic [2:0] REG_KEY_SELECT   = 3'd0;
    localparam logic [2:0] REG_INVERT       = 3'd1;
    localparam logic [2:0] REG_CUSTOM_KEY   = 3'd2;
    localparam logic [2:0] REG_SIMILARITY   = 3'd3;
    localparam logic [2:0] REG_SOFTNESS     = 3'd4;
    localparam logic [2:0] REG_EDGE_SHRINK  = 3'd5;
    localparam logic [2:0] REG_DESPILL      = 3'd6;
    localparam logic [2:0] REG_BALANCE      = 3'd7;

    localparam int FRONT_LAT = 5;
    localparam int SQRT_LAT  = 8;
    localparam int DIV_LAT   = 6;
    localparam int BACK_LAT  = 5;
    localparam int TOTAL_LAT = FRONT_LAT + SQRT_LAT + DIV_LAT + BACK_LAT;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [15:0] a;
    } pix_t;

    typedef struct packed {
        logic [1:0]  key_sel;
        logic        invert;
        logic [15:0] key_r;
        logic [15:0] key_g;
        logic [15:0] key_b;
        logic [15:0] sim;
        logic [15:0] ramp;
        logic [16:0] shrink;
        logic [15:0] despill;
        logic [15:0] balance;
    } cfg_t;

    function automatic logic [15:0] sat_one(input logic [16:0] v);
        return (v > {1'b0, ONE}) ? ONE : v[15:0];
    endfunction

endpackage
`default_nettype wire

### design/ckmd_front.sv
// Front stages: input saturation, key differences, sum of squares, divide by 3, despill.
// Depends on ckmd_pkg.
`default_nettype none
module ckmd_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [15:0]        in_red,
    input  wire logic [15:0]        in_green,
    input  wire logic [15:0]        in_blue,
    input  wire logic [15:0]        in_alpha,
    input  wire ckmd_pkg::cfg_t     cfg,
    output logic                    out_valid,
    output logic [31:0]             out_rad,
    output ckmd_pkg::pix_t          out_pix
);
    logic [15:0] r_s, g_s, b_s, kr, kg, kb, dom, oth;
    logic        blue_key;

    logic           v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    ckmd_pkg::pix_t pix0_reg, pix1_reg, pix2_reg, pix3_reg, pix4_reg;
    logic [15:0]    dr0_reg, dg0_reg, db0_reg, diff0_reg;
    logic           blue0_reg, blue1_reg, blue2_reg;
    logic [30:0]    sq1_reg;
    logic [15:0]    dg1_reg, db1_reg, db2_reg, spill1_reg;
    logic [31:0]    sq2_reg, sq3_reg;
    logic [14:0]    restore2_reg;
    logic [30:0]    q4_reg;
    logic [31:0]    spill_prod, restore_prod;
    logic [63:0]    recip_prod;

    always_comb
    begin
        r_s = ckmd_pkg::sat_one({1'b0, in_red});
        g_s = ckmd_pkg::sat_one({1'b0, in_green});
        b_s = ckmd_pkg::sat_one({1'b0, in_blue});
        blue_key = (cfg.key_sel == ckmd_pkg::KEY_BLUE);
        case (cfg.key_sel)
            ckmd_pkg::KEY_BLUE:
            begin
                kr = '0; kg = '0; kb = ckmd_pkg::ONE;
            end
            ckmd_pkg::KEY_CUSTOM:
            begin
                kr = cfg.key_r; kg = cfg.key_g; kb = cfg.key_b;
            end
            default:
            begin
                kr = '0; kg = ckmd_pkg::ONE; kb = '0;
            end
        endcase
        dom = blue_key ? b_s : g_s;
        if (blue_key)
            oth = (r_s > g_s) ? r_s : g_s;
        else
            oth = (r_s > b_s) ? r_s : b_s;
    end

    assign spill_prod   = diff0_reg * cfg.despill;
    assign restore_prod = spill1_reg * cfg.balance;
    assign recip_prod   = sq3_reg * ckmd_pkg::RECIP3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pix0_reg  <= '{r: r_s, g: g_s, b: b_s,
                       a: ckmd_pkg::sat_one({1'b0, in_alpha})};
        dr0_reg   <= (r_s > kr) ? r_s - kr : kr - r_s;
        dg0_reg   <= (g_s > kg) ? g_s - kg : kg - g_s;
        db0_reg   <= (b_s > kb) ? b_s - kb : kb - b_s;
        diff0_reg <= (dom > oth) ? dom - oth : '0;
        blue0_reg <= blue_key;

        pix1_reg   <= pix0_reg;
        sq1_reg    <= 31'(dr0_reg * dr0_reg);
        dg1_reg    <= dg0_reg;
        db1_reg    <= db0_reg;
        spill1_reg <= spill_prod[30:15];
        blue1_reg  <= blue0_reg;

        pix2_reg.r   <= pix1_reg.r;
        pix2_reg.a   <= pix1_reg.a;
        pix2_reg.g   <= blue1_reg ? pix1_reg.g : pix1_reg.g - spill1_reg;
        pix2_reg.b   <= blue1_reg ? pix1_reg.b - spill1_reg : pix1_reg.b;
        sq2_reg      <= {1'b0, sq1_reg} + 32'(dg1_reg * dg1_reg);
        db2_reg      <= db1_reg;
        restore2_reg <= restore_prod[30:16];
        blue2_reg    <= blue1_reg;

        pix3_reg.g <= pix2_reg.g;
        pix3_reg.a <= pix2_reg.a;
        pix3_reg.r <= ckmd_pkg::sat_one({1'b0, pix2_reg.r} + 17'(restore2_reg));
        pix3_reg.b <= ckmd_pkg::sat_one({1'b0, pix2_reg.b} + 17'(restore2_reg));
        sq3_reg    <= sq2_reg + 32'(db2_reg * db2_reg);

        pix4_reg <= pix3_reg;
        q4_reg   <= recip_prod[63:33];
    end

    assign out_valid = v4_reg;
    assign out_rad   = {1'b0, q4_reg};
    assign out_pix   = pix4_reg;

endmodule
`default_nettype wire

### design/ckmd_sqrt.sv
// Pipelined integer square root, two result bits per stage, eight stages.
// Depends on ckmd_pkg.
`default_nettype none
module ckmd_sqrt (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [31:0]        in_rad,
    input  wire ckmd_pkg::pix_t     in_pix,
    output logic                    out_valid,
    output logic [15:0]             out_root,
    output ckmd_pkg::pix_t          out_pix
);
    localparam int NS = ckmd_pkg::SQRT_LAT;

    logic           v_reg    [1:NS];
    logic [19:0]    rem_reg  [1:NS];
    logic [15:0]    root_reg [1:NS];
    logic [31:0]    rad_reg  [1:NS];
    ckmd_pkg::pix_t pix_reg  [1:NS];

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic           v_src;
        logic [19:0]    rem_src, rem_nx;
        logic [15:0]    root_src, root_nx;
        logic [31:0]    rad_src, rad_nx;
        ckmd_pkg::pix_t pix_src;

        if (s == 0)
        begin : g_first
            assign v_src    = in_valid;
            assign rem_src  = '0;
            assign root_src = '0;
            assign rad_src  = in_rad;
            assign pix_src  = in_pix;
        end
        else
        begin : g_mid
            assign v_src    = v_reg[s];
            assign rem_src  = rem_reg[s];
            assign root_src = root_reg[s];
            assign rad_src  = rad_reg[s];
            assign pix_src  = pix_reg[s];
        end

        always_comb
        begin
            logic [19:0] trial;
            rem_nx  = rem_src;
            root_nx = root_src;
            rad_nx  = rad_src;
            for (int k = 0; k < 2; k++)
            begin
                rem_nx = {rem_nx[17:0], rad_nx[31:30]};
                rad_nx = {rad_nx[29:0], 2'b00};
                trial  = {2'b00, root_nx, 2'b01};
                if (rem_nx >= trial)
                begin
                    rem_nx  = rem_nx - trial;
                    root_nx = {root_nx[14:0], 1'b1};
                end
                else
                    root_nx = {root_nx[14:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else
                v_reg[s+1] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s+1]  <= rem_nx;
            root_reg[s+1] <= root_nx;
            rad_reg[s+1]  <= rad_nx;
            pix_reg[s+1]  <= pix_src;
        end
    end

    assign out_valid = v_reg[NS];
    assign out_root  = root_reg[NS];
    assign out_pix   = pix_reg[NS];

endmodule
`default_nettype wire

### design/ckmd_div.sv
// Ramp position: (d - sim) / soft saturated to 1.0, restoring division three bits per stage.
// Depends on ckmd_pkg.
`default_nettype none
module ckmd_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [15:0]        in_dist,
    input  wire ckmd_pkg::pix_t     in_pix,
    input  wire ckmd_pkg::cfg_t     cfg,
    output logic                    out_valid,
    output logic [15:0]             out_t,
    output ckmd_pkg::pix_t          out_pix
);
    localparam int NS = ckmd_pkg::DIV_LAT - 1;
    localparam int BPS = 15 / NS;

    logic [15:0] diff;

    logic           v_reg    [0:NS];
    logic [15:0]    rem_reg  [0:NS];
    logic [14:0]    quo_reg  [0:NS];
    logic           zero_reg [0:NS];
    logic           full_reg [0:NS];
    ckmd_pkg::pix_t pix_reg  [0:NS];

    assign diff = in_dist - cfg.sim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        zero_reg[0] <= (in_dist <= cfg.sim);
        full_reg[0] <= (in_dist > cfg.sim) && (diff >= cfg.ramp);
        rem_reg[0]  <= diff;
        quo_reg[0]  <= '0;
        pix_reg[0]  <= in_pix;
    end

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic [15:0] rem_nx;
        logic [14:0] quo_nx;

        always_comb
        begin
            logic [16:0] wide;
            rem_nx = rem_reg[s];
            quo_nx = quo_reg[s];
            for (int k = 0; k < BPS; k++)
            begin
                wide = {rem_nx, 1'b0};
                if (wide >= {1'b0, cfg.ramp})
                begin
                    wide   = wide - {1'b0, cfg.ramp};
                    quo_nx = {quo_nx[13:0], 1'b1};
                end
                else
                    quo_nx = {quo_nx[13:0], 1'b0};
                rem_nx = wide[15:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else
                v_reg[s+1] <= v_reg[s];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s+1]  <= rem_nx;
            quo_reg[s+1]  <= quo_nx;
            zero_reg[s+1] <= zero_reg[s];
            full_reg[s+1] <= full_reg[s];
            pix_reg[s+1]  <= pix_reg[s];
        end
    end

    assign out_valid = v_reg[NS];
    assign out_pix   = pix_reg[NS];
    assign out_t     = zero_reg[NS] ? '0 :
                       full_reg[NS] ? ckmd_pkg::ONE : {1'b0, quo_reg[NS]};

endmodule
`default_nettype wire

### design/ckmd_back.sv
// Back stages: smoothstep, edge shrink, invert, alpha and premultiply, transparency flag.
// Depends on ckmd_pkg.
`default_nettype none
module ckmd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [15:0]        in_t,
    input  wire ckmd_pkg::pix_t     in_pix,
    input  wire ckmd_pkg::cfg_t     cfg,
    output logic                    out_valid,
    output ckmd_pkg::pix_t          out_pix,
    output logic                    out_transparent
);
    logic           v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    ckmd_pkg::pix_t pix1_reg, pix2_reg, pix3_reg, pix4_reg, pix5_reg;
    logic [15:0]    t1_reg, t2_1_reg, m3_reg, oa4_reg;
    logic [16:0]    sm2_reg;
    logic           tr5_reg;

    logic [31:0]        sq_prod, sm_prod;
    logic [16:0]        factor;
    logic signed [18:0] msum;
    logic [15:0]        mclamp;
    logic [31:0]        a_prod, r_prod, g_prod, b_prod;

    assign sq_prod = in_t * in_t;
    assign factor  = ckmd_pkg::THREE_ONE - {t1_reg, 1'b0};
    assign sm_prod = t2_1_reg * factor;
    assign msum    = $signed({2'b00, sm2_reg}) + 19'($signed(cfg.shrink));
    assign a_prod  = pix3_reg.a * m3_reg;
    assign r_prod  = pix4_reg.r * oa4_reg;
    assign g_prod  = pix4_reg.g * oa4_reg;
    assign b_prod  = pix4_reg.b * oa4_reg;

    always_comb
    begin
        if (msum < 0)
            mclamp = '0;
        else if (msum > 19'sd32768)
            mclamp = ckmd_pkg::ONE;
        else
            mclamp = msum[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pix1_reg <= in_pix;
        t1_reg   <= in_t;
        t2_1_reg <= sq_prod[30:15];

        pix2_reg <= pix1_reg;
        sm2_reg  <= sm_prod[31:15];

        pix3_reg <= pix2_reg;
        m3_reg   <= cfg.invert ? ckmd_pkg::ONE - mclamp : mclamp;

        pix4_reg <= pix3_reg;
        oa4_reg  <= ckmd_pkg::sat_one(a_prod[31:15]);

        pix5_reg.r <= r_prod[30:15];
        pix5_reg.g <= g_prod[30:15];
        pix5_reg.b <= b_prod[30:15];
        pix5_reg.a <= oa4_reg;
        tr5_reg    <= (oa4_reg < ckmd_pkg::ALPHA_THRESH);
    end

    assign out_valid       = v5_reg;
    assign out_pix         = pix5_reg;
    assign out_transparent = tr5_reg;

endmodule
`default_nettype wire

### design/chroma_key_matte_despill.sv
// Chroma key matte with despill: top level, config registers and pipeline assembly.
// Throughput: one word per cycle, busy is always low.
// The result is shown for one cycle with done; the pipeline has no stall path.
// Reset: asynchronous, clears pipeline valid bits and loads register defaults.
// Depends on ckmd_pkg, ckmd_front, ckmd_sqrt, ckmd_div, ckmd_back.
`default_nettype none
module chroma_key_matte_despill (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] in_red,
    input  wire logic [15:0] in_green,
    input  wire logic [15:0] in_blue,
    input  wire logic [15:0] in_alpha,
    output logic             done,
    output logic [15:0]      out_red,
    output logic [15:0]      out_green,
    output logic [15:0]      out_blue,
    output logic [15:0]      out_alpha,
    output logic             is_transparent,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);
    logic [1:0]  key_sel_reg;
    logic        invert_reg;
    logic [47:0] custom_reg;
    logic [15:0] sim_reg, soft_reg, despill_reg, balance_reg;
    logic [16:0] shrink_reg;

    ckmd_pkg::cfg_t cfg;
    logic [15:0]    soft_sat;

    logic           f_valid, s_valid, d_valid, b_valid;
    logic [31:0]    f_rad;
    logic [15:0]    s_root, d_t;
    ckmd_pkg::pix_t f_pix, s_pix, d_pix, b_pix;
    logic           b_transp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_sel_reg <= '0;
            invert_reg  <= 1'b0;
            custom_reg  <= '0;
            sim_reg     <= 16'd13107;
            soft_reg    <= 16'd3277;
            shrink_reg  <= '0;
            despill_reg <= 16'd16384;
            balance_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ckmd_pkg::REG_KEY_SELECT:  key_sel_reg <= cfg_data[1:0];
                ckmd_pkg::REG_INVERT:      invert_reg  <= cfg_data[0];
                ckmd_pkg::REG_CUSTOM_KEY:  custom_reg  <= cfg_data;
                ckmd_pkg::REG_SIMILARITY:  sim_reg     <= cfg_data[15:0];
                ckmd_pkg::REG_SOFTNESS:    soft_reg    <= cfg_data[15:0];
                ckmd_pkg::REG_EDGE_SHRINK: shrink_reg  <= cfg_data[16:0];
                ckmd_pkg::REG_DESPILL:     despill_reg <= cfg_data[15:0];
                ckmd_pkg::REG_BALANCE:     balance_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign soft_sat = ckmd_pkg::sat_one({1'b0, soft_reg});

    always_comb
    begin
        cfg.key_sel = key_sel_reg;
        cfg.invert  = invert_reg;
        cfg.key_r   = ckmd_pkg::sat_one({1'b0, custom_reg[47:32]});
        cfg.key_g   = ckmd_pkg::sat_one({1'b0, custom_reg[31:16]});
        cfg.key_b   = ckmd_pkg::sat_one({1'b0, custom_reg[15:0]});
        cfg.sim     = ckmd_pkg::sat_one({1'b0, sim_reg});
        cfg.ramp    = (soft_sat == '0) ? 16'd1 : soft_sat;
        cfg.shrink  = shrink_reg;
        cfg.despill = ckmd_pkg::sat_one({1'b0, despill_reg});
        cfg.balance = ckmd_pkg::sat_one({1'b0, balance_reg});
    end

    assign busy = 1'b0;

    ckmd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .in_alpha  (in_alpha),
        .cfg       (cfg),
        .out_valid (f_valid),
        .out_rad   (f_rad),
        .out_pix   (f_pix)
    );

    ckmd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_rad    (f_rad),
        .in_pix    (f_pix),
        .out_valid (s_valid),
        .out_root  (s_root),
        .out_pix   (s_pix)
    );

    ckmd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .in_dist   (s_root),
        .in_pix    (s_pix),
        .cfg       (cfg),
        .out_valid (d_valid),
        .out_t     (d_t),
        .out_pix   (d_pix)
    );

    ckmd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (d_valid),
        .in_t            (d_t),
        .in_pix          (d_pix),
        .cfg             (cfg),
        .out_valid       (b_valid),
        .out_pix         (b_pix),
        .out_transparent (b_transp)
    );

    assign done           = b_valid;
    assign out_red        = b_pix.r;
    assign out_green      = b_pix.g;
    assign out_blue       = b_pix.b;
    assign out_alpha      = b_pix.a;
    assign is_transparent = b_transp;

    a_transp_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_transparent == (out_alpha < ckmd_pkg::ALPHA_THRESH)))
        else $error("transparent flag disagrees with alpha");

    a_premult: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_red <= out_alpha && out_green <= out_alpha && out_blue <= out_alpha))
        else $error("premultiplied color exceeds alpha");

    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_alpha <= ckmd_pkg::ONE))
        else $error("alpha above one");

endmodule
`default_nettype wire

### sim/tb_top.sv
// Testbench for chroma_key_matte_despill: directed table then random pixels, each
// result checked against an in-bench matte/despill predictor. Depends on ckmd_pkg and the DUT.
`timescale 1ns / 1ps
module tb_top;

    typedef struct {
        logic [15:0] r, g, b, a;
        logic        has_exp;
        logic [15:0] er, eg, eb, ea;
        logic        et;
    } row_t;

    typedef struct {
        logic [15:0] r, g, b, a;
        logic        t;
    } px_out_t;

    localparam int LIMIT = 400000;

    logic        clk, rst_n, start, busy, done, is_transparent, cfg_we;
    logic [15:0] in_red, in_green, in_blue, in_alpha;
    logic [15:0] out_red, out_green, out_blue, out_alpha;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;

    logic [1:0]  key_sel_q;
    logic        invert_q;
    logic [47:0] custom_q;
    logic [15:0] sim_q, soft_q, despill_q, balance_q;
    logic [16:0] shrink_q;

    px_out_t pending_px[$];
    int      errors, cycles, idle_pct;

    chroma_key_matte_despill dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .in_red(in_red), .in_green(in_green), .in_blue(in_blue), .in_alpha(in_alpha),
        .done(done), .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
        .out_alpha(out_alpha), .is_transparent(is_transparent),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned sat1(longint unsigned v);
        return v > 32768 ? 32768 : v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, lo, hi, mid;
        lo = 0;
        hi = 65536;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        r = lo;
        return r;
    endfunction

    function automatic longint unsigned adiff(longint unsigned x, longint unsigned y);
        return x > y ? x - y : y - x;
    endfunction

    function automatic px_out_t key_pixel(logic [15:0] ir, ig, ib, ia);
        longint unsigned r, g, b, a, kr, kg, kb, dst, sim, ramp, t, t2, matte;
        longint unsigned dom, oth, diff, spill, restore, oa;
        longint          m;
        logic            blue_key;
        px_out_t         o;
        r = sat1(ir); g = sat1(ig); b = sat1(ib); a = sat1(ia);
        blue_key = (key_sel_q == ckmd_pkg::KEY_BLUE);
        if (blue_key)
        begin
            kr = 0; kg = 0; kb = 32768;
        end
        else if (key_sel_q == ckmd_pkg::KEY_CUSTOM)
        begin
            kr = sat1(custom_q[47:32]); kg = sat1(custom_q[31:16]); kb = sat1(custom_q[15:0]);
        end
        else
        begin
            kr = 0; kg = 32768; kb = 0;
        end
        dst = int_sqrt((adiff(r, kr) ** 2 + adiff(g, kg) ** 2 + adiff(b, kb) ** 2) / 3);
        sim = sat1(sim_q);
        ramp = sat1(soft_q);
        if (ramp == 0) ramp = 1;
        t = 0;
        if (dst > sim) t = sat1(((dst - sim) << ckmd_pkg::FB) / ramp);
        t2 = (t * t) >> ckmd_pkg::FB;
        matte = (t2 * (3 * 32768 - 2 * t)) >> ckmd_pkg::FB;
        m = longint'(matte) + longint'($signed(shrink_q));
        if (m < 0) m = 0;
        if (m > 32768) m = 32768;
        matte = m;
        if (invert_q) matte = 32768 - matte;
        dom = blue_key ? b : g;
        oth = blue_key ? (r > g ? r : g) : (r > b ? r : b);
        diff = dom > oth ? dom - oth : 0;
        spill = (diff * sat1(despill_q)) >> ckmd_pkg::FB;
        if (blue_key) b = b - spill;
        else g = g - spill;
        restore = (spill * sat1(balance_q)) >> (ckmd_pkg::FB + 1);
        r = sat1(r + restore);
        b = sat1(b + restore);
        oa = sat1((a * matte) >> ckmd_pkg::FB);
        o.r = 16'((r * oa) >> ckmd_pkg::FB);
        o.g = 16'((g * oa) >> ckmd_pkg::FB);
        o.b = 16'((b * oa) >> ckmd_pkg::FB);
        o.a = 16'(oa);
        o.t = oa < ckmd_pkg::ALPHA_THRESH;
        return o;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        case (idx)
            ckmd_pkg::REG_KEY_SELECT:  key_sel_q = val[1:0];
            ckmd_pkg::REG_INVERT:      invert_q = val[0];
            ckmd_pkg::REG_CUSTOM_KEY:  custom_q = val;
            ckmd_pkg::REG_SIMILARITY:  sim_q = val[15:0];
            ckmd_pkg::REG_SOFTNESS:    soft_q = val[15:0];
            ckmd_pkg::REG_EDGE_SHRINK: shrink_q = val[16:0];
            ckmd_pkg::REG_DESPILL:     despill_q = val[15:0];
            ckmd_pkg::REG_BALANCE:     balance_q = val[15:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic drain_pipe();
        start <= 0;
        while (pending_px.size() != 0) @(negedge clk);
        repeat (ckmd_pkg::TOTAL_LAT + 4) @(negedge clk);
    endtask

    // Drives one word; expected is queued at the accepting edge.
    task automatic send_pixel(logic [15:0] r, g, b, a, logic has_exp, px_out_t e);
        px_out_t p;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            @(negedge clk);
        end
        start <= 1;
        in_red <= r; in_green <= g; in_blue <= b; in_alpha <= a;
        p = key_pixel(r, g, b, a);
        if (has_exp && (p.r != e.r || p.g != e.g || p.b != e.b || p.a != e.a || p.t != e.t))
        begin
            $error("table row disagrees with predictor for %h %h %h %h", r, g, b, a);
            errors++;
        end
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_px.push_back(has_exp ? e : p);
        @(negedge clk);
    endtask

    function automatic logic [15:0] rnd_chan();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom_range(65535));
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    always @(posedge clk)
    begin
        px_out_t e;
        if (rst_n && done)
        begin
            if (pending_px.size() == 0)
            begin
                $error("unexpected result word");
                errors++;
            end
            else
            begin
                e = pending_px.pop_front();
                if (out_red !== e.r)
                begin
                    $error("out_red exp %0d got %0d", e.r, out_red); errors++;
                end
                if (out_green !== e.g)
                begin
                    $error("out_green exp %0d got %0d", e.g, out_green); errors++;
                end
                if (out_blue !== e.b)
                begin
                    $error("out_blue exp %0d got %0d", e.b, out_blue); errors++;
                end
                if (out_alpha !== e.a)
                begin
                    $error("out_alpha exp %0d got %0d", e.a, out_alpha); errors++;
                end
                if (is_transparent !== e.t)
                begin
                    $error("is_transparent exp %0d got %0d", e.t, is_transparent); errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    row_t    dir_rows[$];
    px_out_t e0;

    initial
    begin
        int k;
        row_t rw;
        errors = 0; cycles = 0; idle_pct = 0;
        start = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
        in_red = 0; in_green = 0; in_blue = 0; in_alpha = 0;
        key_sel_q = 0; invert_q = 0; custom_q = 0; sim_q = 13107; soft_q = 3277;
        shrink_q = 0; despill_q = 16384; balance_q = 0;
        rst_n = 0;
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // pure green key: fully transparent; black at full alpha: opaque black
        dir_rows = '{
            '{0, 32768, 0, 32768, 1, 0, 0, 0, 0, 1},
            '{0, 0, 0, 32768, 1, 0, 0, 0, 32768, 0},
            '{0, 0, 0, 0, 1, 0, 0, 0, 0, 1},
            '{32768, 32768, 32768, 32768, 0, 0, 0, 0, 0, 0},
            '{65535, 65535, 65535, 65535, 0, 0, 0, 0, 0, 0},
            '{32768, 0, 32768, 32768, 0, 0, 0, 0, 0, 0},
            '{10000, 30000, 5000, 20000, 0, 0, 0, 0, 0, 0},
            '{20000, 20000, 20000, 327, 0, 0, 0, 0, 0, 0},
            '{0, 32768, 0, 40000, 0, 0, 0, 0, 0, 0},
            '{5000, 25000, 30000, 32768, 0, 0, 0, 0, 0, 0}
        };
        foreach (dir_rows[i])
        begin
            rw = dir_rows[i];
            e0 = '{rw.er, rw.eg, rw.eb, rw.ea, rw.et};
            send_pixel(rw.r, rw.g, rw.b, rw.a, rw.has_exp, e0);
        end
        drain_pipe();

        // extremes of the registers, unused selector, zero softness
        write_reg(ckmd_pkg::REG_KEY_SELECT, 48'd3);
        write_reg(ckmd_pkg::REG_SOFTNESS, 48'd0);
        write_reg(ckmd_pkg::REG_SIMILARITY, 48'd0);
        write_reg(ckmd_pkg::REG_DESPILL, 48'hFFFF);
        write_reg(ckmd_pkg::REG_BALANCE, 48'hFFFF);
        write_reg(ckmd_pkg::REG_EDGE_SHRINK, 48'h10000);
        write_reg(ckmd_pkg::REG_INVERT, 48'd1);
        for (k = 0; k < 6; k++) send_pixel(rnd_chan(), rnd_chan(), rnd_chan(), rnd_chan(), 0, e0);
        drain_pipe();
        write_reg(ckmd_pkg::REG_KEY_SELECT, 48'(ckmd_pkg::KEY_CUSTOM));
        write_reg(ckmd_pkg::REG_CUSTOM_KEY, 48'hFFFF_FFFF_FFFF);
        write_reg(ckmd_pkg::REG_EDGE_SHRINK, 48'h0FFFF);
        write_reg(ckmd_pkg::REG_SIMILARITY, 48'hFFFF);
        for (k = 0; k < 5; k++) send_pixel(rnd_chan(), rnd_chan(), rnd_chan(), rnd_chan(), 0, e0);
        drain_pipe();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 45;
                2: idle_pct = 14;
                default: idle_pct = 45;
            endcase
            write_reg(ckmd_pkg::REG_KEY_SELECT, 48'($urandom_range(3)));
            write_reg(ckmd_pkg::REG_INVERT, 48'($urandom_range(1)));
            write_reg(ckmd_pkg::REG_CUSTOM_KEY,
                      {16'(rnd_chan()), 16'(rnd_chan()), 16'(rnd_chan())});
            write_reg(ckmd_pkg::REG_SIMILARITY,
                      48'($urandom_range(3) == 0 ? rnd_chan() : $urandom_range(20000)));
            write_reg(ckmd_pkg::REG_SOFTNESS,
                      48'($urandom_range(3) == 0 ? rnd_chan() : $urandom_range(12000)));
            write_reg(ckmd_pkg::REG_EDGE_SHRINK,
                      48'($urandom_range(1) ? 17'($urandom) : 17'd0));
            write_reg(ckmd_pkg::REG_DESPILL, 48'(rnd_chan()));
            write_reg(ckmd_pkg::REG_BALANCE, 48'(rnd_chan()));
            if (ph == 7)
                write_reg(ckmd_pkg::REG_BALANCE, 48'($urandom) << 16 | 48'($urandom));
            for (k = 0; k < 116; k++)
                send_pixel(rnd_chan(), rnd_chan(), rnd_chan(), rnd_chan(), 0, e0);
            drain_pipe();
        end

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
